// ===== rtl/hcwg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hcwg_pkg;

  localparam int EVENT_CAPACITY = 32;
  localparam int IDX_W  = $clog2(EVENT_CAPACITY);
  localparam int CNT_W  = $clog2(EVENT_CAPACITY + 1);
  localparam int ADDR_W = IDX_W + 1;

  localparam int CHAN_W = 12;
  localparam int TAC_W  = 2;
  localparam int EN_W   = 24;
  localparam int TIME_W = 62;
  localparam int WIN_W  = 20;
  localparam int SIZE_W = 6;

  localparam int S_TDATA_W = 104;
  localparam int M_TDATA_W = 112;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 20'd20000;

  typedef struct packed {
    logic [CHAN_W-1:0] channel_id;
    logic [TAC_W-1:0]  tac_id;
    logic [EN_W-1:0]   energy;
    logic [TIME_W-1:0] hit_time;
  } hit_t;

  // one closed event waiting to be drained
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] count;
    logic             drop;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    hit_t              data;
  } wr_t;

  // bank drained, free for the front again
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage
`default_nettype wire

// ===== rtl/hit_coincidence_window_grouper_core.sv =====
// channel  | dir | handshake                     | payload
// s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata hit fields, tuser kind
// m_axis   | out | m_axis_tvalid / m_axis_tready | tdata hit + size, tuser overflow, tlast
// cfg      | in  | cfg_we_i                      | cfg_wdata_i = window_ps
//
// The front takes a hit or flush whenever it is ready; an event of two or more hits
// drains through the single read port of the event memory, one transfer a cycle unless
// m_axis_tready stalls it, with a pause to take the next event from the command queue.
// The memory holds two banks of EVENT_CAPACITY hits: the front stalls only when a hit
// must open a window in a bank whose previous event is still draining.
// Reset clears control state only; the memory needs no clearing pass.
// At the earliest, m_axis_tvalid rises after the closing command has passed the command
// queue, the back's drain state, the memory read register and the output register.
`timescale 1ns / 1ps
`default_nettype none
module hit_coincidence_window_grouper_core
  import hcwg_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [WIN_W-1:0]     cfg_wdata_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // channel_id [11:0], tac_id [13:12], energy [37:14], hit_time [99:38]
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  // kind [0]
  input  wire logic                 s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // out_channel_id [11:0], out_tac_id [13:12], out_energy [37:14],
  // out_time [99:38], event_size [105:100]
  output logic [M_TDATA_W-1:0]      m_axis_tdata,
  // overflowed [0]
  output logic                      m_axis_tuser,
  // last_of_event
  output logic                      m_axis_tlast
);

  hit_t              in_hit, out_hit;
  wr_t               wr;
  cmd_t              cmd_push, cmd_head;
  rel_t              rel;
  logic              push, pop, cmd_valid;
  logic [SIZE_W-1:0] out_size;

  assign in_hit.channel_id = s_axis_tdata[11:0];
  assign in_hit.tac_id     = s_axis_tdata[13:12];
  assign in_hit.energy     = s_axis_tdata[37:14];
  assign in_hit.hit_time   = s_axis_tdata[99:38];

  hcwg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_kind_i   (s_axis_tuser),
    .in_hit_i    (in_hit),
    .wr_o        (wr),
    .push_o      (push),
    .cmd_o       (cmd_push),
    .rel_i       (rel)
  );

  hcwg_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_push),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_head)
  );

  hcwg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .pop_o       (pop),
    .rel_o       (rel),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_hit_o   (out_hit),
    .out_size_o  (out_size),
    .out_drop_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_size, out_hit.hit_time, out_hit.energy,
                         out_hit.tac_id, out_hit.channel_id};

endmodule
`default_nettype wire

// ===== rtl/hcwg_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hcwg_front
  import hcwg_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [WIN_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             in_kind_i,
  input  wire hit_t             in_hit_i,
  output wr_t                   wr_o,
  output logic                  push_o,
  output cmd_t                  cmd_o,
  input  wire rel_t             rel_i
);

  logic [WIN_W-1:0]  window_q;
  logic [TIME_W-1:0] ref_q, ref_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              drop_q, drop_d;
  logic              cur_q, cur_d;
  logic [1:0]        busy_q, busy_d;

  logic [TIME_W:0]   d_fwd, d_bwd;
  logic [TIME_W-1:0] diff;
  logic              in_win, cnt_zero, multi, accept, nb;

  always_comb begin
    d_fwd  = {1'b0, in_hit_i.hit_time} - {1'b0, ref_q};
    d_bwd  = {1'b0, ref_q} - {1'b0, in_hit_i.hit_time};
    diff   = d_fwd[TIME_W] ? d_bwd[TIME_W-1:0] : d_fwd[TIME_W-1:0];
    in_win = diff < {{(TIME_W-WIN_W){1'b0}}, window_q};
  end

  assign cnt_zero = (count_q == '0);
  assign multi    = (count_q >= CNT_W'(2));

  assign in_ready_o = !(!in_kind_i && ((cnt_zero && busy_q[cur_q]) ||
                        (!cnt_zero && !in_win && multi && busy_q[!cur_q])));
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    ref_d      = ref_q;
    count_d    = count_q;
    drop_d     = drop_q;
    cur_d      = cur_q;
    nb         = cur_q;
    wr_o.en    = 1'b0;
    wr_o.addr  = {cur_q, count_q[IDX_W-1:0]};
    wr_o.data  = in_hit_i;
    push_o     = 1'b0;
    cmd_o.bank = cur_q;
    cmd_o.count = count_q;
    cmd_o.drop = drop_q;
    if (accept) begin
      if (in_kind_i) begin
        if (multi) begin
          push_o = 1'b1;
          cur_d  = !cur_q;
        end
        count_d = '0;
        drop_d  = 1'b0;
      end else if (cnt_zero) begin
        wr_o.en   = 1'b1;
        wr_o.addr = {cur_q, {IDX_W{1'b0}}};
        ref_d     = in_hit_i.hit_time;
        count_d   = CNT_W'(1);
        drop_d    = 1'b0;
      end else if (in_win) begin
        if (count_q < CNT_W'(EVENT_CAPACITY)) begin
          wr_o.en = 1'b1;
          count_d = count_q + CNT_W'(1);
        end else begin
          drop_d = 1'b1;
        end
      end else begin
        if (multi) begin
          push_o = 1'b1;
          nb     = !cur_q;
          cur_d  = !cur_q;
        end
        wr_o.en   = 1'b1;
        wr_o.addr = {nb, {IDX_W{1'b0}}};
        ref_d     = in_hit_i.hit_time;
        count_d   = CNT_W'(1);
        drop_d    = 1'b0;
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (rel_i.valid) busy_d[rel_i.bank] = 1'b0;
    if (push_o) busy_d[cmd_o.bank] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
      ref_q    <= '0;
      count_q  <= '0;
      drop_q   <= 1'b0;
      cur_q    <= 1'b0;
      busy_q   <= '0;
    end else begin
      if (cfg_we_i) window_q <= cfg_wdata_i;
      ref_q   <= ref_d;
      count_q <= count_d;
      drop_q  <= drop_d;
      cur_q   <= cur_d;
      busy_q  <= busy_d;
    end
  end

  a_wr_free_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> !busy_q[wr_o.addr[IDX_W]])
    else $error("write into a bank still being drained");

  a_rel_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_i.valid |-> busy_q[rel_i.bank])
    else $error("release of a bank that is not busy");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(EVENT_CAPACITY))
    else $error("event count beyond capacity");

endmodule
`default_nettype wire

// ===== rtl/hcwg_cmd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hcwg_cmd_fifo
  import hcwg_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      cmd_o
);

  cmd_t       slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != 2'd2) || pop_i)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("command queue underflow");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("command queue count out of range");

endmodule
`default_nettype wire

// ===== rtl/hcwg_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hcwg_back
  import hcwg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wr_t               wr_i,
  input  wire logic              cmd_valid_i,
  input  wire cmd_t              cmd_i,
  output logic                   pop_o,
  output rel_t                   rel_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output hit_t                   out_hit_o,
  output logic [SIZE_W-1:0]      out_size_o,
  output logic                   out_drop_o,
  output logic                   out_last_o
);

  hit_t mem [2*EVENT_CAPACITY];

  logic             active_q;
  logic             bank_q;
  logic [CNT_W-1:0] n_q;
  logic             drop_q;
  logic [IDX_W-1:0] k_q;

  hit_t             rdata_q;
  logic             rv_q;
  logic [CNT_W-1:0] rsize_q;
  logic             rdrop_q, rlast_q;

  logic             ov_q;
  logic             adv, issue, last_issue;

  assign adv        = rv_q && (!ov_q || out_ready_i);
  assign issue      = active_q && (!rv_q || adv);
  assign last_issue = issue && ({1'b0, k_q} == (n_q - CNT_W'(1)));
  assign pop_o      = !active_q && cmd_valid_i;
  assign rel_o.valid = last_issue;
  assign rel_o.bank  = bank_q;
  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem[wr_i.addr] <= wr_i.data;
    if (issue) begin
      rdata_q <= mem[{bank_q, k_q}];
      rsize_q <= n_q;
      rdrop_q <= drop_q;
      rlast_q <= last_issue;
    end
    if (adv) begin
      out_hit_o  <= rdata_q;
      out_size_o <= SIZE_W'(rsize_q);
      out_drop_o <= rdrop_q;
      out_last_o <= rlast_q;
    end
    if (pop_o) begin
      bank_q <= cmd_i.bank;
      n_q    <= cmd_i.count;
      drop_q <= cmd_i.drop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      k_q      <= '0;
      rv_q     <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      if (pop_o) begin
        active_q <= 1'b1;
        k_q      <= '0;
      end else if (issue) begin
        k_q <= k_q + IDX_W'(1);
        if (last_issue) active_q <= 1'b0;
      end
      if (issue) rv_q <= 1'b1;
      else if (adv) rv_q <= 1'b0;
      if (adv) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  a_active_multi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (n_q >= CNT_W'(2)))
    else $error("draining an event of fewer than two hits");

  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> ({1'b0, k_q} < n_q))
    else $error("read index past event end");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_issue |=> !active_q)
    else $error("drain did not end after last read");

endmodule
`default_nettype wire
